// File: rtl/lzcp_pkg.sv
// Shared types and constants of the Landau-Zener crossing probability pipeline.
package lzcp_pkg;

	// register map, word index taken from paddr[3:2]
	localparam logic [1:0] REG_SOC     = 2'd0;
	localparam logic [1:0] REG_GRAD    = 2'd1;
	localparam logic [1:0] REG_MASS    = 2'd2;
	localparam logic [1:0] REG_BARRIER = 2'd3;

	localparam logic [23:0] GRAD_RST = 24'd1048576;
	localparam logic [19:0] MASS_RST = 20'd256;

	localparam logic [16:0] ONE   = 17'd65536;
	localparam logic [23:0] COEF  = 24'd16227753;
	localparam logic [30:0] EXPM1 = 31'd1580030169;
	localparam logic [20:0] YSAT  = 21'd1310720;

	localparam int EXP_TERMS = 13;
	localparam int K_MAX     = 19;

	// floor(2^32 / n) for the series divisors
	localparam logic [31:0] RECIP [2:13] = '{
		32'd2147483648, 32'd1431655765, 32'd1073741824, 32'd858993459,
		32'd715827882, 32'd613566756, 32'd536870912, 32'd477218588,
		32'd429496729, 32'd390451572, 32'd357913941, 32'd330382099
	};

	// fix: result already decided, val holds it
	typedef struct packed {
		logic        fix;
		logic [16:0] val;
		logic        below;
	} lzcp_tag_t;

endpackage

// File: rtl/lzcp_exp.sv
// Pipelined exp(-y) for y in Q.16: Taylor series on the fraction, then exp(-1) scaling.
module lzcp_exp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  lzcp_pkg::lzcp_tag_t in_tag,
	input  logic [20:0]         y,
	output logic                out_vld,
	output lzcp_pkg::lzcp_tag_t out_tag,
	output logic [32:0]         v
);
	localparam int SER_N = 3 * (lzcp_pkg::EXP_TERMS - 1);
	localparam int SC0   = SER_N + 1;
	localparam int NE    = SC0 + lzcp_pkg::K_MAX;

	logic                vld_s [0:NE-1];
	lzcp_pkg::lzcp_tag_t tag_s [0:NE-1];
	logic [4:0]          k_s   [0:NE-1];
	logic [31:0]         u_s   [0:SER_N];
	logic [31:0]         trm_s [0:SER_N];
	logic [34:0]         sum_s [0:SER_N];
	logic [31:0]         xa_s  [2:lzcp_pkg::EXP_TERMS];
	logic [31:0]         xb_s  [2:lzcp_pkg::EXP_TERMS];
	logic [31:0]         qb_s  [2:lzcp_pkg::EXP_TERMS];
	logic [32:0]         v_s   [0:lzcp_pkg::K_MAX-1];
	lzcp_pkg::lzcp_tag_t sat_tag;

	function automatic logic [31:0] mul_hi32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return p[63:32];
	endfunction

	// reciprocal estimate is low by at most one
	function automatic logic [31:0] fix_div(input logic [31:0] x, input logic [31:0] q0,
			input logic [3:0] n);
		logic [35:0] rm;
		rm = 36'(x) - 36'(q0) * 36'(n);
		return (rm >= 36'(n)) ? q0 + 32'd1 : q0;
	endfunction

	function automatic logic [32:0] e1_mul(input logic [32:0] a);
		logic [63:0] p;
		p = 64'(a) * 64'(lzcp_pkg::EXPM1);
		return 33'(p[63:32]);
	endfunction

	function automatic logic [32:0] clamp(input logic [34:0] s);
		return s[34] ? 33'd0 : s[32:0];
	endfunction

	always_comb begin
		sat_tag = in_tag;
		if (!in_tag.fix && y >= lzcp_pkg::YSAT) begin
			sat_tag.fix   = 1'b1;
			sat_tag.val   = lzcp_pkg::ONE;
			sat_tag.below = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NE; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < NE; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= sat_tag;
			k_s[0]   <= y[20:16];
			u_s[0]   <= {y[15:0], 16'd0};
			trm_s[0] <= {y[15:0], 16'd0};
			sum_s[0] <= 35'h1_0000_0000 - {3'd0, y[15:0], 16'd0};
			for (int i = 1; i < NE; i++) begin
				tag_s[i] <= tag_s[i-1];
				k_s[i]   <= k_s[i-1];
			end
			for (int i = 1; i <= SER_N; i++) begin
				u_s[i] <= u_s[i-1];
				if ((i % 3) != 0) begin
					trm_s[i] <= trm_s[i-1];
					sum_s[i] <= sum_s[i-1];
				end
			end
			// three stages per term: product, reciprocal product, correct and accumulate
			for (int n = 2; n <= lzcp_pkg::EXP_TERMS; n++) begin
				xa_s[n] <= mul_hi32(trm_s[3*n-6], u_s[3*n-6]);
				xb_s[n] <= xa_s[n];
				qb_s[n] <= mul_hi32(xa_s[n], lzcp_pkg::RECIP[n]);
				trm_s[3*n-3] <= fix_div(xb_s[n], qb_s[n], 4'(n));
				if ((n & 1) != 0)
					sum_s[3*n-3] <= sum_s[3*n-4] - {3'd0, fix_div(xb_s[n], qb_s[n], 4'(n))};
				else
					sum_s[3*n-3] <= sum_s[3*n-4] + {3'd0, fix_div(xb_s[n], qb_s[n], 4'(n))};
			end
			v_s[0] <= (k_s[SC0-1] != 5'd0) ? e1_mul(clamp(sum_s[SER_N])) : clamp(sum_s[SER_N]);
			for (int j = 1; j < lzcp_pkg::K_MAX; j++)
				v_s[j] <= (5'(j) < k_s[SC0+j-1]) ? e1_mul(v_s[j-1]) : v_s[j-1];
		end
	end

	assign out_vld = vld_s[NE-1];
	assign out_tag = tag_s[NE-1];
	assign v       = v_s[lzcp_pkg::K_MAX-1];

endmodule

// File: rtl/landau_zener_cell_probability.sv
// Top level: Landau-Zener crossing probability per energy cell, fully pipelined.
// Pipeline from an accepted request to m_tvalid: 102 stages of divide, square
// root, multiply and divide, 56 stages of exp, one output register.
// Throughput: one request per cycle; the whole pipeline stalls only while m_tvalid waits.
// Reset clears all valid bits and loads the registers with their reset values.
module landau_zener_cell_probability #(
	parameter int MAX_CELLS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] cell_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [16:0] probability, [23:17] zero
	output logic [0:0]  m_tuser   // [0] below_threshold
);
	localparam int DV_N = 52;
	localparam int SQ_N = 26;
	localparam int DQ_N = 21;
	localparam int I_SQ = DV_N;
	localparam int I_MU = I_SQ + SQ_N;
	localparam int I_DQ = I_MU + 3;
	localparam int NT   = I_DQ + DQ_N;

	logic        en;
	logic [19:0] soc_q, mass_q;
	logic [23:0] grad_q, barrier_q;
	logic [39:0] ss_q, p_q;
	logic [43:0] pa_q, pb_q;
	logic [63:0] psum;

	logic [22:0]         bpos;
	logic [24:0]         e4_full;
	logic [51:0]         dvd;
	lzcp_pkg::lzcp_tag_t in_tag;

	logic                vld_s [0:NT-1];
	lzcp_pkg::lzcp_tag_t tag_s [0:NT-1];

	logic [19:0] dv_rem_s [0:DV_N-1];
	logic [51:0] dv_quo_s [0:DV_N-1];
	logic [19:0] dv_e4_s  [0:DV_N-1];
	logic [20:0] dv_st    [0:DV_N-1];

	logic [27:0] sq_rem_s  [0:SQ_N-1];
	logic [25:0] sq_root_s [0:SQ_N-1];
	logic [51:0] sq_rad_s  [0:SQ_N-1];
	logic [53:0] sq_st     [0:SQ_N-1];

	logic [45:0]         mul_a_s1, mul_b_s1;
	logic [65:0]         mul_prod_s2;
	logic [47:0]         dq_dvd_s3;
	logic                sat;
	lzcp_pkg::lzcp_tag_t sat_tag;

	logic [23:0] dq_rem_s [0:DQ_N-1];
	logic [20:0] dq_quo_s [0:DQ_N-1];
	logic [20:0] dq_low_s [0:DQ_N-1];
	logic [24:0] dq_st    [0:DQ_N-1];

	logic                x_vld;
	lzcp_pkg::lzcp_tag_t x_tag;
	logic [32:0]         x_v;

	logic        out_vld_q, below_q;
	logic [16:0] prob_q, prob_nxt;
	logic [33:0] vr;
	logic [17:0] t2, t2c;

	function automatic logic [20:0] dv_step(input logic [19:0] rem, input logic b,
			input logic [19:0] d);
		logic [20:0] t, df;
		t  = {rem, b};
		df = t - {1'b0, d};
		return (t >= {1'b0, d}) ? {1'b1, df[19:0]} : {1'b0, t[19:0]};
	endfunction

	function automatic logic [53:0] sq_step(input logic [27:0] rem, input logic [25:0] root,
			input logic [1:0] pair);
		logic [29:0] t, tr, df;
		t  = {rem, pair};
		tr = {2'd0, root, 2'b01};
		df = t - tr;
		return (t >= tr) ? {root[24:0], 1'b1, df[27:0]} : {root[24:0], 1'b0, t[27:0]};
	endfunction

	function automatic logic [24:0] dq_step(input logic [23:0] rem, input logic b,
			input logic [23:0] d);
		logic [24:0] t, df;
		t  = {rem, b};
		df = t - {1'b0, d};
		return (t >= {1'b0, d}) ? {1'b1, df[23:0]} : {1'b0, t[23:0]};
	endfunction

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soc_q     <= '0;
			grad_q    <= lzcp_pkg::GRAD_RST;
			mass_q    <= lzcp_pkg::MASS_RST;
			barrier_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				lzcp_pkg::REG_SOC:     soc_q     <= pwdata[19:0];
				lzcp_pkg::REG_GRAD:    grad_q    <= pwdata[23:0];
				lzcp_pkg::REG_MASS:    mass_q    <= pwdata[19:0];
				lzcp_pkg::REG_BARRIER: barrier_q <= pwdata[23:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lzcp_pkg::REG_SOC:     prdata = 32'(soc_q);
			lzcp_pkg::REG_GRAD:    prdata = 32'(grad_q);
			lzcp_pkg::REG_MASS:    prdata = 32'(mass_q);
			lzcp_pkg::REG_BARRIER: prdata = 32'(barrier_q);
		endcase
	end

	// coupling term S*S*C >> 24, registered through ss_q, pa_q/pb_q and p_q after a write
	assign psum = {pa_q, 20'd0} + {20'd0, pb_q};

	always_ff @(posedge clk) begin
		ss_q <= 40'(soc_q) * 40'(soc_q);
		pa_q <= 44'(ss_q[39:20]) * 44'(lzcp_pkg::COEF);
		pb_q <= 44'(ss_q[19:0]) * 44'(lzcp_pkg::COEF);
		p_q  <= psum[63:24];
	end

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// cell energy and early decisions
	assign bpos    = barrier_q[23] ? 23'd0 : barrier_q[22:0];
	assign e4_full = {5'd0, s_tdata, 4'd8} - {2'd0, bpos};
	assign dvd     = {mass_q, 32'd0};

	always_comb begin
		in_tag = '0;
		priority if (32'(s_tdata) >= 32'(MAX_CELLS)) begin
			in_tag.fix = 1'b1;
		end else if (e4_full[24]) begin
			in_tag.fix   = 1'b1;
			in_tag.below = 1'b1;
		end else if (soc_q == '0 || mass_q == '0) begin
			in_tag.fix = 1'b1;
		end else if (grad_q == '0 || e4_full[19:0] == '0) begin
			in_tag.fix = 1'b1;
			in_tag.val = lzcp_pkg::ONE;
		end
	end

	// large exponent: product overflow or quotient of 2^21 or more
	assign sat = (mul_prod_s2[65:64] != 2'd0) ||
		(mul_prod_s2[63:16] >= {3'd0, grad_q, 21'd0});

	always_comb begin
		sat_tag = tag_s[I_MU+1];
		if (!sat_tag.fix && sat) begin
			sat_tag.fix   = 1'b1;
			sat_tag.val   = lzcp_pkg::ONE;
			sat_tag.below = 1'b0;
		end
	end

	always_comb begin
		dv_st[0] = dv_step(20'd0, dvd[51], e4_full[19:0]);
		for (int j = 1; j < DV_N; j++)
			dv_st[j] = dv_step(dv_rem_s[j-1], dvd[51-j], dv_e4_s[j-1]);
		sq_st[0] = sq_step(28'd0, 26'd0, dv_quo_s[DV_N-1][51:50]);
		for (int j = 1; j < SQ_N; j++)
			sq_st[j] = sq_step(sq_rem_s[j-1], sq_root_s[j-1], sq_rad_s[j-1][51-2*j -: 2]);
		dq_st[0] = dq_step(dq_dvd_s3[44:21], dq_dvd_s3[20], grad_q);
		for (int j = 1; j < DQ_N; j++)
			dq_st[j] = dq_step(dq_rem_s[j-1], dq_low_s[j-1][20-j], grad_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < NT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			for (int i = 1; i < NT; i++)
				tag_s[i] <= (i == I_MU + 2) ? sat_tag : tag_s[i-1];

			// q = (M << 32) / E4, one quotient bit per stage
			dv_rem_s[0] <= dv_st[0][19:0];
			dv_quo_s[0] <= {51'd0, dv_st[0][20]};
			dv_e4_s[0]  <= e4_full[19:0];
			for (int j = 1; j < DV_N; j++) begin
				dv_rem_s[j] <= dv_st[j][19:0];
				dv_quo_s[j] <= {dv_quo_s[j-1][50:0], dv_st[j][20]};
				dv_e4_s[j]  <= dv_e4_s[j-1];
			end

			// r = floor(sqrt(q)), one root bit per stage
			sq_rem_s[0]  <= sq_st[0][27:0];
			sq_root_s[0] <= sq_st[0][53:28];
			sq_rad_s[0]  <= dv_quo_s[DV_N-1];
			for (int j = 1; j < SQ_N; j++) begin
				sq_rem_s[j]  <= sq_st[j][27:0];
				sq_root_s[j] <= sq_st[j][53:28];
				sq_rad_s[j]  <= sq_rad_s[j-1];
			end

			// p*r split into two partial products
			mul_a_s1    <= 46'(p_q[39:20]) * 46'(sq_root_s[SQ_N-1]);
			mul_b_s1    <= 46'(p_q[19:0]) * 46'(sq_root_s[SQ_N-1]);
			mul_prod_s2 <= {mul_a_s1, 20'd0} + {20'd0, mul_b_s1};
			dq_dvd_s3   <= mul_prod_s2[63:16];

			// Y = (p*r >> 16) / G, 21 quotient bits
			dq_rem_s[0] <= dq_st[0][23:0];
			dq_quo_s[0] <= {20'd0, dq_st[0][24]};
			dq_low_s[0] <= dq_dvd_s3[20:0];
			for (int j = 1; j < DQ_N; j++) begin
				dq_rem_s[j] <= dq_st[j][23:0];
				dq_quo_s[j] <= {dq_quo_s[j-1][19:0], dq_st[j][24]};
				dq_low_s[j] <= dq_low_s[j-1];
			end
		end
	end

	lzcp_exp u_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s[NT-1]),
		.in_tag  (tag_s[NT-1]),
		.y       (dq_quo_s[DQ_N-1]),
		.out_vld (x_vld),
		.out_tag (x_tag),
		.v       (x_v)
	);

	// round t^2 to Q.16 and take the complement
	assign vr       = {1'b0, x_v} + 34'd32768;
	assign t2       = vr[33:16];
	assign t2c      = (t2 > 18'(lzcp_pkg::ONE)) ? 18'(lzcp_pkg::ONE) : t2;
	assign prob_nxt = x_tag.fix ? x_tag.val : 17'(18'(lzcp_pkg::ONE) - t2c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= x_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prob_q  <= prob_nxt;
			below_q <= x_tag.below;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = {7'd0, prob_q};
	assign m_tuser[0] = below_q;

`ifndef ASSERT_OFF
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[DV_N-1] && !tag_s[DV_N-1].fix) |->
		((72'(dv_quo_s[DV_N-1]) * 72'(dv_e4_s[DV_N-1]) <= 72'({mass_q, 32'd0})) &&
		 ((72'(dv_quo_s[DV_N-1]) + 72'd1) * 72'(dv_e4_s[DV_N-1]) > 72'({mass_q, 32'd0}))))
		else $error("divider quotient off");

	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[I_SQ+SQ_N-1] |-> (sq_rem_s[SQ_N-1] <= {1'b0, sq_root_s[SQ_N-1], 1'b0}))
		else $error("square root remainder too large");

	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[16:0] == 17'd0))
		else $error("below threshold with nonzero probability");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] <= lzcp_pkg::ONE))
		else $error("probability above one");
`endif

endmodule
